/* rtl/sliding_window_range_min_core_defines.svh */
// Assertion macros for the sliding window range-min core
`ifndef SLIDING_WINDOW_RANGE_MIN_CORE_DEFINES_SVH
`define SLIDING_WINDOW_RANGE_MIN_CORE_DEFINES_SVH

// same-cycle implication
`define SWRM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swrm check failed");

// next-cycle implication
`define SWRM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swrm check failed");

`endif

/* rtl/swrm_pkg.sv */
// Shared types and constants for the sliding window range-min core
`default_nettype none
package swrm_pkg;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 7;
    localparam logic [DATA_W-1:0] BEST_INIT = '1;

    typedef struct packed {
        logic load;
        logic drop_min;
        logic drop_max;
        logic push;
        logic emit;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic min_exp;
        logic max_exp;
        logic full;
        logic last;
        logic out_free;
    } t_sts;
endpackage
`default_nettype wire

/* rtl/sliding_window_range_min_core.sv */
// Top level of the sliding window range-min core
// Usage:
//   Slave channel s_*: one signed 32-bit sample per beat in s_tdata, s_tlast
//   closes the stream. Master channel m_*: m_tdata carries window_range in
//   bits 31:0 and best_range in bits 63:32, m_tlast flags the closing sample.
//   Config channel i_cfg_*: window length (1..MAX_WINDOW, 0 acts as 1),
//   which the user must write only while the core is idle, as the core does not enforce it; always ready.
//   Each sample goes through the states accept, drop, push and emit before
//   the core takes the next one. In the drop step each queue sheds its own
//   expired front, one per cycle (0 or 1 fronts per sample at a steady
//   window length, more just after the window shrinks).
//   The next sample is taken once the previous one has finished; a result
//   sitting in the output register does not block it.
//   No result until the window has filled. A last beat also clears the
//   queues, the sample count and the best range.
//   Reset clears both queues, the window length goes to 1.
//   A stalled receiver holds the result; the core waits in its final step
//   for the register to free up before producing another.
`default_nettype none
module sliding_window_range_min_core #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [swrm_pkg::DATA_W-1:0]   s_tdata,   // sample
    input  wire logic                          s_tlast,   // last_sample
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [2*swrm_pkg::DATA_W-1:0]      m_tdata,   // window_range, best_range
    output logic                               m_tlast,   // is_last
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [swrm_pkg::CFG_W-1:0]    i_cfg_data  // window length
);
    import swrm_pkg::*;

    logic [CFG_W-1:0] r_win;
    t_cmd             cmd;
    t_sts             sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            r_win <= i_cfg_data;
        end
    end

    swrm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_tvalid), .o_ready(s_tready),
        .i_sts(sts), .o_cmd(cmd)
    );

    swrm_dp #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_sample(s_tdata), .i_last(s_tlast), .i_win(r_win),
        .o_tdata(m_tdata), .o_tlast(m_tlast), .o_tvalid(m_tvalid), .i_tready(m_tready)
    );
endmodule
`default_nettype wire

/* rtl/swrm_queue.sv */
// Monotonic queue as a row of cells with parallel pop compare
`default_nettype none
module swrm_queue #(
    parameter int MAX_WINDOW = 64,
    parameter bit IS_MIN     = 1'b1
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic signed [swrm_pkg::DATA_W-1:0] i_x,
    input  wire logic [swrm_pkg::DATA_W-1:0]      i_now,
    input  wire logic [swrm_pkg::DATA_W-1:0]      i_w,
    input  wire logic                             i_drop,
    input  wire logic                             i_push,
    input  wire logic                             i_clear,
    output logic signed [swrm_pkg::DATA_W-1:0]    o_front,
    output logic                                  o_front_exp
);
    import swrm_pkg::*;

    logic signed [DATA_W-1:0] r_val [MAX_WINDOW];
    logic [DATA_W-1:0]        r_pos [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]    r_vld;
    logic [MAX_WINDOW-1:0]    keep;
    logic [MAX_WINDOW-1:0]    put;
    logic [DATA_W-1:0]        age;

    always_comb begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            keep[i] = r_vld[i] && !(IS_MIN ? (i_x <= r_val[i]) : (i_x >= r_val[i]));
        end
        put[0] = !keep[0];
        for (int i = 1; i < MAX_WINDOW; i++) begin
            put[i] = !keep[i] && keep[i-1];
        end
    end

    assign age         = i_now - r_pos[0];
    assign o_front     = r_val[0];
    assign o_front_exp = r_vld[0] && (age >= i_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_clear) begin
            r_vld <= '0;
        end else if (i_drop) begin
            r_vld <= r_vld >> 1;
        end else if (i_push) begin
            r_vld <= keep | put;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_drop) begin
            for (int i = 0; i < MAX_WINDOW - 1; i++) begin
                r_val[i] <= r_val[i+1];
                r_pos[i] <= r_pos[i+1];
            end
        end else if (i_push) begin
            for (int i = 0; i < MAX_WINDOW; i++) begin
                if (put[i]) begin
                    r_val[i] <= i_x;
                    r_pos[i] <= i_now;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/swrm_dp.sv */
// Datapath: sample latch, both queues, counter, best range, result register
`default_nettype none
module swrm_dp #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire swrm_pkg::t_cmd                i_cmd,
    output swrm_pkg::t_sts                     o_sts,
    input  wire logic [swrm_pkg::DATA_W-1:0]   i_sample,
    input  wire logic                          i_last,
    input  wire logic [swrm_pkg::CFG_W-1:0]    i_win,
    output logic [2*swrm_pkg::DATA_W-1:0]      o_tdata,
    output logic                               o_tlast,
    output logic                               o_tvalid,
    input  wire logic                          i_tready
);
    import swrm_pkg::*;

    logic signed [DATA_W-1:0] r_x;
    logic                     r_last;
    logic [DATA_W-1:0]        r_now;
    logic                     r_full;
    logic [DATA_W-1:0]        r_best;
    logic [2*DATA_W-1:0]      r_odata;
    logic                     r_olast;
    logic                     r_ovalid;
    logic [DATA_W-1:0]        w;
    logic [DATA_W-1:0]        win_ext;
    logic [DATA_W-1:0]        now_inc;
    logic [DATA_W-1:0]        range;
    logic [DATA_W-1:0]        n_best;
    logic signed [DATA_W-1:0] min_front;
    logic signed [DATA_W-1:0] max_front;
    logic                     min_exp;
    logic                     max_exp;

    assign win_ext = {{(DATA_W-CFG_W){1'b0}}, i_win};
    always_comb begin
        if (win_ext == '0) begin
            w = DATA_W'(1);
        end else if (win_ext > DATA_W'(MAX_WINDOW)) begin
            w = DATA_W'(MAX_WINDOW);
        end else begin
            w = win_ext;
        end
    end

    swrm_queue #(.MAX_WINDOW(MAX_WINDOW), .IS_MIN(1'b1)) u_minq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_x(r_x), .i_now(r_now), .i_w(w),
        .i_drop(i_cmd.drop_min), .i_push(i_cmd.push), .i_clear(i_cmd.clear),
        .o_front(min_front), .o_front_exp(min_exp)
    );

    swrm_queue #(.MAX_WINDOW(MAX_WINDOW), .IS_MIN(1'b0)) u_maxq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_x(r_x), .i_now(r_now), .i_w(w),
        .i_drop(i_cmd.drop_max), .i_push(i_cmd.push), .i_clear(i_cmd.clear),
        .o_front(max_front), .o_front_exp(max_exp)
    );

    assign now_inc = r_now + DATA_W'(1);
    assign range   = DATA_W'(max_front) - DATA_W'(min_front);
    assign n_best  = (range < r_best) ? range : r_best;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_sample;
            r_last <= i_last;
        end
        if (i_cmd.emit) begin
            r_odata <= {n_best, range};
            r_olast <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now    <= '0;
            r_full   <= 1'b0;
            r_best   <= BEST_INIT;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_now  <= '0;
                r_full <= 1'b0;
                r_best <= BEST_INIT;
            end else begin
                if (i_cmd.push) begin
                    r_now  <= now_inc;
                    r_full <= r_full || (now_inc >= w);
                end
                if (i_cmd.emit) begin
                    r_best <= n_best;
                end
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_sts.min_exp  = min_exp;
    assign o_sts.max_exp  = max_exp;
    assign o_sts.full     = r_full;
    assign o_sts.last     = r_last;
    assign o_sts.out_free = !r_ovalid || i_tready;

    assign o_tdata  = r_odata;
    assign o_tlast  = r_olast;
    assign o_tvalid = r_ovalid;
endmodule
`default_nettype wire

/* rtl/swrm_ctrl.sv */
// Controller: sequences accept, expiry drops, push and result per sample
`default_nettype none
module swrm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire swrm_pkg::t_sts i_sts,
    output swrm_pkg::t_cmd      o_cmd
);
    import swrm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DROP = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DROP;
                end
            end
            ST_DROP: begin
                o_cmd.drop_min = i_sts.min_exp;
                o_cmd.drop_max = i_sts.max_exp;
                if (!i_sts.min_exp && !i_sts.max_exp) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_sts.full) begin
                    o_cmd.clear = i_sts.last;
                    n_state     = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.clear = i_sts.last;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

/* rtl/swrm_checker.sv */
// Port-level checks for the sliding window range-min core, with bind
`default_nettype none
`include "sliding_window_range_min_core_defines.svh"
module swrm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic        m_tlast
);
    `SWRM_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `SWRM_ASSERT_NOW(a_best, i_clk, i_rst_n, m_tvalid, m_tdata[63:32] <= m_tdata[31:0])
    `SWRM_ASSERT_NXT(a_busy, i_clk, i_rst_n, s_tvalid && s_tready, !s_tready)
endmodule

bind sliding_window_range_min_core swrm_checker u_swrm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the sliding window range-min core
`default_nettype none
module tb;
    localparam int MAXW = 64;
    localparam int LIMIT = 2000000;

    typedef struct packed {
        logic        last;
        logic [31:0] sample;
    } t_sample;

    typedef struct packed {
        logic        last;
        logic [31:0] best;
        logic [31:0] range;
    } t_result;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic s_tlast = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [63:0] m_tdata;
    logic m_tlast;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic [6:0] i_cfg_data = '0;

    sliding_window_range_min_core #(.MAX_WINDOW(MAXW)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // predictor state
    logic [6:0]  win_reg = 7'd1;
    logic signed [31:0] minv [$];
    logic [31:0] minp [$];
    logic signed [31:0] maxv [$];
    logic [31:0] maxp [$];
    logic [31:0] taken = 0;
    logic [31:0] best = '1;
    logic        full = 0;

    t_sample pending [$];
    t_result expected [$];
    int errors = 0;
    int n_results = 0;
    int n_samples = 0;
    int cycles = 0;
    bit hold_off = 0;

    function automatic void track_window(input logic signed [31:0] x, input logic last);
        logic [31:0] w;
        logic [31:0] rng;
        w = {25'd0, win_reg};
        if (w == 32'd0) w = 32'd1;
        else if (w > 32'(MAXW)) w = 32'(MAXW);
        while (minp.size() > 0 && taken - minp[0] >= w) begin
            minv.delete(0); minp.delete(0);
        end
        while (maxp.size() > 0 && taken - maxp[0] >= w) begin
            maxv.delete(0); maxp.delete(0);
        end
        while (minv.size() > 0 && x <= minv[$]) begin
            minv.delete(minv.size() - 1); minp.delete(minp.size() - 1);
        end
        while (maxv.size() > 0 && x >= maxv[$]) begin
            maxv.delete(maxv.size() - 1); maxp.delete(maxp.size() - 1);
        end
        minv.insert(minv.size(), x); minp.insert(minp.size(), taken);
        maxv.insert(maxv.size(), x); maxp.insert(maxp.size(), taken);
        taken = taken + 32'd1;
        if (taken >= w) full = 1'b1;
        if (full) begin
            rng = maxv[0] - minv[0];
            if (rng < best) best = rng;
            expected.insert(expected.size(), t_result'{last: last, best: best, range: rng});
        end
        if (last) begin
            minv.delete(); minp.delete(); maxv.delete(); maxp.delete();
            taken = 32'd0; best = '1; full = 1'b0;
        end
    endfunction

    logic s_tready_q = 0;
    always @(posedge i_clk) s_tready_q <= s_tready;

    // driver
    int gap_in = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready_q) begin
                track_window($signed(s_tdata), s_tlast);
                n_samples++;
                gap_in = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
                if ($urandom_range(0, 3) == 0) gap_in = 0;
                if (gap_in == 0 && pending.size() > 0) begin
                    {s_tlast, s_tdata} <= pending[0];
                    pending.delete(0);
                end else begin
                    s_tvalid <= 0;
                end
            end else if (!s_tvalid) begin
                if (gap_in > 0) gap_in--;
                else if (pending.size() > 0) begin
                    {s_tlast, s_tdata} <= pending[0];
                    pending.delete(0);
                    s_tvalid <= 1;
                end
            end
        end
    end

    // monitor
    int gap_out = 0;
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            got = '{last: m_tlast, best: m_tdata[63:32], range: m_tdata[31:0]};
            n_results++;
            if (expected.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat %h", got);
            end else begin
                want = expected[0];
                expected.delete(0);
                if (got != want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: range %h/%h best %h/%h last %b/%b",
                                 want.range, got.range, want.best, got.best,
                                 want.last, got.last);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off) m_tready <= 0;
        else if (!m_tready || m_tvalid) begin
            if (gap_out > 0) begin
                gap_out--;
                m_tready <= 0;
            end else if (!m_tready) begin
                m_tready <= 1;
            end else begin
                gap_out = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
                m_tready <= (gap_out == 0);
            end
        end
    end

    task automatic add_sample(input logic [31:0] v, input logic last);
        pending.insert(pending.size(), t_sample'{last: last, sample: v});
    endtask

    task automatic settle();
        while (pending.size() > 0 || s_tvalid || expected.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_window(input logic [6:0] w);
        @(negedge i_clk);
        i_cfg_data <= w;
        i_cfg_valid <= 1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        win_reg = w;
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    function automatic logic [31:0] rand_value(input int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 15) - 8;
            2: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                           : 32'h80000000 + $urandom_range(0, 3);
            default: return $urandom_range(0, 200);
        endcase
    endfunction

    initial begin
        int run;
        int mode;
        logic [6:0] wsel;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, ties, short stream, window 1
        add_sample(32'h80000000, 1'b0);
        add_sample(32'h7fffffff, 1'b0);
        add_sample(32'h7fffffff, 1'b0);
        add_sample(32'h80000000, 1'b1);
        settle();
        set_window(7'd3);
        add_sample(32'd5, 1'b1);
        add_sample(32'd5, 1'b0);
        add_sample(32'd5, 1'b0);
        add_sample(32'hffffffff, 1'b0);
        add_sample(32'd0, 1'b0);
        add_sample(32'h7fffffff, 1'b0);
        add_sample(32'h80000000, 1'b0);
        add_sample(32'd1, 1'b1);
        settle();
        set_window(7'd0);
        add_sample(32'd7, 1'b0);
        add_sample(32'd9, 1'b1);
        settle();
        set_window(7'd127);
        for (int i = 0; i < 70; i++) add_sample(i[0] ? 32'h80000000 : i, i == 69);
        settle();

        // receiver held off while samples keep coming
        set_window(7'd4);
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
        join_none
        for (int i = 0; i < 30; i++) add_sample($urandom(), 1'b0);
        settle();

        // random streams, window changes between phases
        while (n_samples < 1550) begin
            case ($urandom_range(0, 5))
                0: wsel = 7'd1;
                1: wsel = 7'd64;
                2: wsel = 7'($urandom_range(65, 127));
                default: wsel = 7'($urandom_range(1, 12));
            endcase
            set_window(wsel);
            for (int s = 0; s < 4; s++) begin
                run = $urandom_range(0, 4) == 0 ? $urandom_range(1, 8) : $urandom_range(5, 40);
                mode = $urandom_range(0, 3);
                for (int i = 0; i < run; i++)
                    add_sample(rand_value(mode), (i == run - 1) && ($urandom_range(0, 5) != 0));
            end
            settle();
        end
        repeat (50) @(posedge i_clk);
        $display("%0d samples sent, %0d results checked over several window lengths",
                 n_samples, n_results);
        if (errors == 0 && expected.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results outstanding", errors, expected.size());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
